/* rtl/hom_pkg.sv */
package hom_pkg;

    localparam int unsigned CURRENT_W   = 16;
    localparam int unsigned RETRY_W     = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned COUNT_WIDTH = 8;

    localparam logic [CURRENT_W-1:0] OVERCURRENT_LIMIT_RST = 16'd250;
    localparam logic [CURRENT_W-1:0] SHUTDOWN_LIMIT_RST    = 16'd500;
    localparam logic [CURRENT_W-1:0] PROG_ACK_LIMIT_RST    = 16'd0;
    localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RST       = 8'd3;
    localparam logic                 PROG_MODE_RST         = 1'b0;

    typedef enum logic [1:0] {
        MODE_OFF         = 2'd0,
        MODE_ON          = 2'd1,
        MODE_OVERCURRENT = 2'd2,
        MODE_SHUTDOWN    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERCURRENT_LIMIT = 3'd0,
        REG_SHUTDOWN_LIMIT    = 3'd1,
        REG_PROG_ACK_LIMIT    = 3'd2,
        REG_RETRY_LIMIT       = 3'd3,
        REG_PROG_MODE         = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [CURRENT_W-1:0] overcurrent_limit;
        logic [CURRENT_W-1:0] shutdown_limit;
        logic [CURRENT_W-1:0] prog_ack_limit;
        logic [RETRY_W-1:0]   retry_limit;
        logic                 prog_mode;
    } t_cfg;

    typedef struct packed {
        logic [CURRENT_W-1:0] current_ma;
        logic                 bridge_enabled;
    } t_in_item;

    typedef struct packed {
        t_mode bridge_state;
        logic  disable_bridge;
        logic  prog_short;
        logic  prog_ack;
        logic  shutdown_event;
        logic  short_event;
    } t_out_item;

endpackage

/* rtl/hom_if.sv */
interface hom_in_if import hom_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CURRENT_W-1:0] current_ma;
    logic                 bridge_enabled;

    modport source (output valid, output current_ma, output bridge_enabled, input ready);
    modport sink   (input valid, input current_ma, input bridge_enabled, output ready);
endinterface

interface hom_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] bridge_state;
    logic       disable_bridge;
    logic       prog_short;
    logic       prog_ack;
    logic       shutdown_event;
    logic       short_event;

    modport source (
        output valid, output bridge_state, output disable_bridge, output prog_short,
        output prog_ack, output shutdown_event, output short_event, input ready
    );
    modport sink (
        input valid, input bridge_state, input disable_bridge, input prog_short,
        input prog_ack, input shutdown_event, input short_event, output ready
    );
endinterface

interface hom_cfg_if import hom_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/hbridge_overcurrent_monitor_unit.sv */
// H-bridge overcurrent monitor. Each input item is one poll tick: a current
// reading in mA and the present bridge enable level. Every item yields exactly
// one result item with the new bridge state (off, on, overcurrent, shutdown),
// a request to drop the bridge enable, the programming-track short and ack
// flags, and shutdown or short event flags for reporting state changes. A
// reading at or above the shutdown limit shuts the bridge down at once; one at
// or above the overcurrent limit trips only after the retry counter has
// reached the retry limit, the counter saturating at its full scale. One item
// is taken every clock cycle unless the output stalls. An accepted item is
// held in the input register, then the evaluation stage updates the mode and
// retry counter and loads the result register. Limits are written through the
// configuration channel, which is always ready; write them only while no items
// are in flight.
module hbridge_overcurrent_monitor_unit import hom_pkg::*; #(
    parameter int unsigned COUNT_W = COUNT_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hom_in_if.sink    i_in,
    hom_out_if.source o_out,
    hom_cfg_if.sink   i_cfg
);

    t_cfg      cfg;
    t_in_item  stage_item;
    logic      stage_valid;
    logic      stage_take;

    // limit registers
    hom_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // hold the incoming tick until the evaluation stage takes it
    hom_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // compare against the limits, advance the mode and counter, register the result
    hom_eval_stage #(
        .COUNT_W (COUNT_W)
    ) u_eval_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (stage_valid),
        .i_item  (stage_item),
        .o_take  (stage_take),
        .o_out   (o_out)
    );

endmodule

/* rtl/hom_cfg_regs.sv */
module hom_cfg_regs import hom_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hom_cfg_if.sink       i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_OVERCURRENT_LIMIT: n_cfg.overcurrent_limit = i_cfg.data;
                REG_SHUTDOWN_LIMIT:    n_cfg.shutdown_limit    = i_cfg.data;
                REG_PROG_ACK_LIMIT:    n_cfg.prog_ack_limit    = i_cfg.data;
                REG_RETRY_LIMIT:       n_cfg.retry_limit       = i_cfg.data[RETRY_W-1:0];
                REG_PROG_MODE:         n_cfg.prog_mode         = i_cfg.data[0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overcurrent_limit <= OVERCURRENT_LIMIT_RST;
            r_cfg.shutdown_limit    <= SHUTDOWN_LIMIT_RST;
            r_cfg.prog_ack_limit    <= PROG_ACK_LIMIT_RST;
            r_cfg.retry_limit       <= RETRY_LIMIT_RST;
            r_cfg.prog_mode         <= PROG_MODE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/hom_in_stage.sv */
module hom_in_stage import hom_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hom_in_if.sink    i_in,
    input  logic      i_take,
    output logic      o_valid,
    output t_in_item  o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // free when empty or when the held item moves on this cycle
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.current_ma     <= i_in.current_ma;
            r_item.bridge_enabled <= i_in.bridge_enabled;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/hom_eval_stage.sv */
module hom_eval_stage import hom_pkg::*; #(
    parameter int unsigned COUNT_W = COUNT_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_take,
    hom_out_if.source o_out
);

    localparam int unsigned CMP_W = (COUNT_W > RETRY_W) ? COUNT_W : RETRY_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    t_mode              r_mode;
    t_mode              n_mode;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    logic               at_shutdown;
    logic               at_overcurrent;
    logic               trip;

    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    assign at_shutdown    = i_item.current_ma >= i_cfg.shutdown_limit;
    assign at_overcurrent = i_item.current_ma >= i_cfg.overcurrent_limit;
    assign trip           = CMP_W'(r_count) >= CMP_W'(i_cfg.retry_limit);

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_out   = '0;

        if (i_cfg.prog_mode) begin
            if (at_overcurrent) begin
                n_out.prog_short = 1'b1;
            end else if (i_item.current_ma >= i_cfg.prog_ack_limit) begin
                n_out.prog_ack = 1'b1;
            end
        end

        if (at_shutdown) begin
            n_out.disable_bridge = 1'b1;
            n_mode = MODE_SHUTDOWN;
        end else if (at_overcurrent) begin
            // compare first, then count up and hold at full scale
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (trip) begin
                n_out.disable_bridge = 1'b1;
                n_mode = MODE_OVERCURRENT;
            end
        end else if (i_item.bridge_enabled) begin
            n_count = '0;
            n_mode  = MODE_ON;
        end else begin
            n_mode = MODE_OFF;
        end

        if (n_mode != r_mode) begin
            if (r_mode == MODE_SHUTDOWN || n_mode == MODE_SHUTDOWN) begin
                n_out.shutdown_event = 1'b1;
            end else if (r_mode == MODE_OVERCURRENT || n_mode == MODE_OVERCURRENT) begin
                n_out.short_event = 1'b1;
            end
        end

        n_out.bridge_state = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_mode      <= n_mode;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.bridge_state   = r_out.bridge_state;
    assign o_out.disable_bridge = r_out.disable_bridge;
    assign o_out.prog_short     = r_out.prog_short;
    assign o_out.prog_ack       = r_out.prog_ack;
    assign o_out.shutdown_event = r_out.shutdown_event;
    assign o_out.short_event    = r_out.short_event;

endmodule
